// ===== hw/rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg: shared constants for the first-fit free-list allocator
// Field widths, request codes and the rounding mask used by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

	localparam int MODE_W = 2;
	localparam int REQ_W  = 13;
	localparam int ADDR_W = 12;

	// request codes; code 3 has no meaning and is answered with a null result
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REALLOC = 2'd2;

	// sizes round up to a multiple of eight bytes
	localparam int ALIGN_MASK = 7;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit: first-fit allocator over a byte pool
// Top level: header memories and the sequencer that walks the free list.
// ----------------------------------------------------------------------------
// Usage
//   Command port: a transfer is taken on the rising edge where start is high
//   and busy is low; mode, request_size and block_address are sampled there.
//   Result port: done is high for exactly one cycle with result_address,
//   granted and copy_length; the receiver cannot hold it off, so capture it.
//   Every command gives exactly one result.
// Steps from accept to done
//   free, null or invalid request       : answered from idle
//   allocate                            : walk the free list, then split
//                                         (only when the block is split), link
//   reallocate in place                 : size read, answered
//   reallocate that moves               : size read, as allocate, release
//   The walk reads one header per cycle from the header memories (registered
//   read); the rate is set by that read port, the walk length by the list.
//   The next command is taken in the cycle done is shown.
// Reset
//   After arst_n releases, busy stays high while both header memories are
//   swept, slot zero set to the pool.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_free_list_allocator_unit #(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output      logic                        busy,
	input  wire logic [ffa_pkg::MODE_W-1:0]  mode,
	input  wire logic [ffa_pkg::REQ_W-1:0]   request_size,
	input  wire logic [ffa_pkg::ADDR_W-1:0]  block_address,
	output      logic                        done,
	output      logic [ffa_pkg::ADDR_W-1:0]  result_address,
	output      logic                        granted,
	output      logic [ffa_pkg::REQ_W-1:0]   copy_length
);

	import ffa_pkg::*;

	// one header per 8-byte slot
	localparam int SLOTS  = POOL_BYTES / 8;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SIZE_W = $clog2(POOL_BYTES) + 1;
	// link word: {next valid, next slot}
	localparam int LINK_W = SLOT_W + 1;

	logic [SLOT_W-1:0] rd_addr;
	logic [SIZE_W-1:0] size_rdata;
	logic [LINK_W-1:0] link_rdata;
	logic              size_we;
	logic [SLOT_W-1:0] size_waddr;
	logic [SIZE_W-1:0] size_wdata;
	logic              link_we;
	logic [SLOT_W-1:0] link_waddr;
	logic [LINK_W-1:0] link_wdata;

	// Sizes and links sit in separate memories so that a split can write the
	// new header in ST_SPLIT and the granted size plus the predecessor link
	// in ST_LINK, the state after it. Header writes only happen once the last
	// read of a command has been used, and the next read whose data matters is
	// issued at a later edge, so no forwarding path is needed.
	ffa_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (SLOTS)
	) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (size_waddr),
		.wdata (size_wdata),
		.raddr (rd_addr),
		.rdata (size_rdata)
	);

	ffa_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	ffa_ctrl #(
		.POOL_BYTES   (POOL_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.request_size   (request_size),
		.block_address  (block_address),
		.done           (done),
		.result_address (result_address),
		.granted        (granted),
		.copy_length    (copy_length),
		.rd_addr        (rd_addr),
		.size_rdata     (size_rdata),
		.link_rdata     (link_rdata),
		.size_we        (size_we),
		.size_waddr     (size_waddr),
		.size_wdata     (size_wdata),
		.link_we        (link_we),
		.link_waddr     (link_waddr),
		.link_wdata     (link_wdata)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram: single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl: sequencer of the first-fit free-list allocator
// Clears the header memories, walks the free list one header a cycle and
// performs the read-modify-write of headers for allocate, free and reallocate.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl #(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16,
	localparam int SLOTS  = POOL_BYTES / 8,
	localparam int SLOT_W = $clog2(SLOTS),
	localparam int SIZE_W = $clog2(POOL_BYTES) + 1,
	localparam int LINK_W = SLOT_W + 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// command side
	input  wire logic                        start,
	output      logic                        busy,
	input  wire logic [ffa_pkg::MODE_W-1:0]  mode,
	input  wire logic [ffa_pkg::REQ_W-1:0]   request_size,
	input  wire logic [ffa_pkg::ADDR_W-1:0]  block_address,
	output      logic                        done,
	output      logic [ffa_pkg::ADDR_W-1:0]  result_address,
	output      logic                        granted,
	output      logic [ffa_pkg::REQ_W-1:0]   copy_length,
	// header memories
	output      logic [SLOT_W-1:0]           rd_addr,
	input  wire logic [SIZE_W-1:0]           size_rdata,
	input  wire logic [LINK_W-1:0]           link_rdata,
	output      logic                        size_we,
	output      logic [SLOT_W-1:0]           size_waddr,
	output      logic [SIZE_W-1:0]           size_wdata,
	output      logic                        link_we,
	output      logic [SLOT_W-1:0]           link_waddr,
	output      logic [LINK_W-1:0]           link_wdata
);

	import ffa_pkg::*;

	localparam int NEED_W = REQ_W + 1;
	localparam int CW     = ((SIZE_W > NEED_W) ? SIZE_W : NEED_W) + 1;
	localparam int SUM_W  = ((SLOT_W > NEED_W) ? SLOT_W : NEED_W) + 2;
	localparam int OFF_W  = SLOT_W + 5;
	localparam bit HDR_ALIGNED = (HEADER_BYTES % 8) == 0;
	localparam int HDR_SLOTS   = HEADER_BYTES / 8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RSIZE,
		ST_WALK,
		ST_SPLIT,
		ST_LINK,
		ST_RELEASE
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [SLOT_W-1:0]   head_q;
	logic                head_valid_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [SLOT_W-1:0]   prev_q;
	logic                prev_valid_q;
	logic [SLOT_W-1:0]   steps_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   nb_q;
	logic                split_q;
	logic                move_q;
	logic [NEED_W-1:0]   need_q;
	logic [REQ_W-1:0]    req_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [SIZE_W-1:0]   size_q;
	logic [SIZE_W-1:0]   old_q;
	logic [LINK_W-1:0]   link_q;
	logic                done_q;
	logic [ADDR_W-1:0]   result_address_q;
	logic                granted_q;
	logic [REQ_W-1:0]    copy_length_q;

	logic                accept;
	logic [ADDR_W-1:0]   in_off;
	logic                in_slot_ok;
	logic [SLOT_W-1:0]   in_slot;
	logic [NEED_W-1:0]   in_need;
	logic                is_alloc;
	logic                is_free;
	logic                is_resize;
	logic                free_go;
	logic [SLOT_W-1:0]   rd_next;
	logic                rd_next_valid;
	logic                fit;
	logic                big;
	logic [SUM_W-1:0]    nb_sum;
	logic                split_go;
	logic                last_step;
	logic [LINK_W-1:0]   new_link;
	logic [SIZE_W-1:0]   remain;
	logic [ADDR_W-1:0]   grant_addr;

	// ---- request decode ----
	assign accept     = start && (state_q == ST_IDLE);
	assign in_off     = block_address - ADDR_W'(HEADER_BYTES);
	assign in_slot_ok = (32'(block_address) >= 32'(HEADER_BYTES))
		&& (in_off[2:0] == 3'b000)
		&& (32'(in_off >> 3) < 32'(SLOTS));
	assign in_slot    = SLOT_W'(in_off >> 3);
	assign in_need    = (NEED_W'(request_size) + NEED_W'(ALIGN_MASK)) & ~NEED_W'(ALIGN_MASK);
	assign is_alloc   = (mode == MODE_ALLOC)
		|| ((mode == MODE_REALLOC) && (block_address == '0));
	assign is_free    = (mode == MODE_FREE)
		|| ((mode == MODE_REALLOC) && (block_address != '0) && (request_size == '0));
	assign is_resize  = (mode == MODE_REALLOC) && (block_address != '0)
		&& (request_size != '0);
	assign free_go    = accept && is_free && in_slot_ok;

	// ---- walk decode on the header just read ----
	assign rd_next       = link_rdata[SLOT_W-1:0];
	assign rd_next_valid = link_rdata[SLOT_W];
	assign fit       = CW'(size_rdata) >= CW'(need_q);
	assign big       = CW'(size_rdata) > (CW'(need_q) + CW'(HEADER_BYTES));
	assign nb_sum    = SUM_W'(cur_q) + SUM_W'(HDR_SLOTS) + SUM_W'(need_q >> 3);
	assign split_go  = HDR_ALIGNED && big && (nb_sum < SUM_W'(SLOTS));
	assign last_step = steps_q == SLOT_W'(SLOTS - 1);

	assign new_link   = split_q ? {1'b1, nb_q} : link_q;
	assign remain     = SIZE_W'(CW'(size_q) - CW'(need_q) - CW'(HEADER_BYTES));
	assign grant_addr = ADDR_W'((OFF_W'(cur_q) << 3) + OFF_W'(HEADER_BYTES));

	// ---- memory ports ----
	always_comb begin
		rd_addr    = cur_q;
		size_we    = 1'b0;
		size_waddr = cur_q;
		size_wdata = SIZE_W'(need_q);
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = {head_valid_q, head_q};
		case (state_q)
			ST_CLEAR: begin
				size_we    = 1'b1;
				size_waddr = clr_q;
				size_wdata = (clr_q == '0) ? SIZE_W'(POOL_BYTES - HEADER_BYTES) : '0;
				link_we    = 1'b1;
				link_waddr = clr_q;
				link_wdata = '0;
			end
			ST_IDLE: begin
				rd_addr    = is_resize ? in_slot : head_q;
				link_we    = free_go;
				link_waddr = in_slot;
			end
			ST_RSIZE: begin
				rd_addr = head_q;
			end
			ST_WALK: begin
				rd_addr = rd_next;
			end
			ST_SPLIT: begin
				size_we    = 1'b1;
				size_waddr = nb_q;
				size_wdata = remain;
				link_we    = 1'b1;
				link_waddr = nb_q;
				link_wdata = link_q;
			end
			ST_LINK: begin
				size_we    = 1'b1;
				link_we    = prev_valid_q;
				link_waddr = prev_q;
				link_wdata = new_link;
			end
			ST_RELEASE: begin
				link_we = 1'b1;
			end
			default: begin
				rd_addr = cur_q;
			end
		endcase
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			clr_q            <= '0;
			head_q           <= '0;
			head_valid_q     <= 1'b1;
			cur_q            <= '0;
			prev_q           <= '0;
			prev_valid_q     <= 1'b0;
			steps_q          <= '0;
			slot_q           <= '0;
			nb_q             <= '0;
			split_q          <= 1'b0;
			move_q           <= 1'b0;
			need_q           <= '0;
			req_q            <= '0;
			addr_q           <= '0;
			size_q           <= '0;
			old_q            <= '0;
			link_q           <= '0;
			done_q           <= 1'b0;
			result_address_q <= '0;
			granted_q        <= 1'b0;
			copy_length_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_q        <= request_size;
						addr_q       <= block_address;
						need_q       <= in_need;
						slot_q       <= in_slot;
						prev_valid_q <= 1'b0;
						steps_q      <= '0;
						cur_q        <= head_q;
						move_q       <= 1'b0;
						if (is_alloc && head_valid_q) begin
							state_q <= ST_WALK;
						end else if (is_resize && in_slot_ok) begin
							state_q <= ST_RSIZE;
						end else begin
							done_q           <= 1'b1;
							result_address_q <= '0;
							granted_q        <= 1'b0;
							copy_length_q    <= '0;
							if (free_go) begin
								head_q       <= in_slot;
								head_valid_q <= 1'b1;
							end
						end
					end
				end
				ST_RSIZE: begin
					old_q <= size_rdata;
					if (CW'(size_rdata) >= CW'(req_q)) begin
						done_q           <= 1'b1;
						result_address_q <= addr_q;
						granted_q        <= 1'b1;
						copy_length_q    <= '0;
						state_q          <= ST_IDLE;
					end else if (head_valid_q) begin
						move_q  <= 1'b1;
						cur_q   <= head_q;
						state_q <= ST_WALK;
					end else begin
						done_q           <= 1'b1;
						result_address_q <= '0;
						granted_q        <= 1'b0;
						copy_length_q    <= '0;
						state_q          <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (fit) begin
						size_q  <= size_rdata;
						link_q  <= link_rdata;
						split_q <= split_go;
						nb_q    <= SLOT_W'(nb_sum);
						state_q <= split_go ? ST_SPLIT : ST_LINK;
					end else if (!rd_next_valid || last_step) begin
						done_q           <= 1'b1;
						result_address_q <= '0;
						granted_q        <= 1'b0;
						copy_length_q    <= '0;
						state_q          <= ST_IDLE;
					end else begin
						prev_q       <= cur_q;
						prev_valid_q <= 1'b1;
						cur_q        <= rd_next;
						steps_q      <= steps_q + 1'b1;
					end
				end
				ST_SPLIT: begin
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					if (!prev_valid_q) begin
						head_q       <= new_link[SLOT_W-1:0];
						head_valid_q <= new_link[SLOT_W];
					end
					if (move_q) begin
						state_q <= ST_RELEASE;
					end else begin
						done_q           <= 1'b1;
						result_address_q <= grant_addr;
						granted_q        <= 1'b1;
						copy_length_q    <= '0;
						state_q          <= ST_IDLE;
					end
				end
				ST_RELEASE: begin
					head_q           <= slot_q;
					head_valid_q     <= 1'b1;
					done_q           <= 1'b1;
					result_address_q <= grant_addr;
					granted_q        <= 1'b1;
					copy_length_q    <= REQ_W'(old_q);
					state_q          <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign result_address = result_address_q;
	assign granted        = granted_q;
	assign copy_length    = copy_length_q;

	// ---- checks ----
	a_free_sets_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && link_we |=> head_valid_q)
		else $error("free did not leave a valid list head");

	a_prev_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && prev_valid_q |-> (steps_q != '0))
		else $error("walk has a predecessor but no step taken");

	a_null_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !granted_q |-> (result_address_q == '0) && (copy_length_q == '0))
		else $error("refused request carries a non-zero payload");

	a_size_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		size_we |-> (state_q == ST_CLEAR) || (state_q == ST_SPLIT) || (state_q == ST_LINK))
		else $error("size memory written outside clear or commit");

	a_split_beyond_cur: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPLIT) |-> (nb_q != cur_q))
		else $error("split header lands on the block being granted");

endmodule

`default_nettype wire

// ===== tb/allocator_checker.sv =====
// ----------------------------------------------------------------------------
// allocator_checker: result checking for the first-fit free-list allocator
// Keeps its own copy of the free list, works out the grant for each accepted
// command and compares every result with the oldest grant still due.
// ----------------------------------------------------------------------------
`default_nettype none

module allocator_checker #(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [ffa_pkg::MODE_W-1:0]  mode,
	input  wire logic [ffa_pkg::REQ_W-1:0]   request_size,
	input  wire logic [ffa_pkg::ADDR_W-1:0]  block_address,
	input  wire logic                        done,
	input  wire logic [ffa_pkg::ADDR_W-1:0]  result_address,
	input  wire logic                        granted,
	input  wire logic [ffa_pkg::REQ_W-1:0]   copy_length,
	output int                               mismatches,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import ffa_pkg::*;

	localparam int SLOT_COUNT = POOL_BYTES / 8;
	localparam int LINK_W     = $clog2(SLOT_COUNT);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              grant;
		logic [REQ_W-1:0]  copy;
	} grant_t;

	// header per 8-byte slot: payload size, link to next free slot
	logic [REQ_W-1:0]  hdr_len     [SLOT_COUNT];
	logic [LINK_W-1:0] hdr_link    [SLOT_COUNT];
	bit                hdr_link_ok [SLOT_COUNT];
	logic [LINK_W-1:0] list_head;
	bit                list_ok;

	grant_t grants_due[$];
	int     errors = 0;

	assign mismatches = errors;

	// first-fit walk; returns the payload offset before masking, 0 on failure
	function automatic int unsigned carve_block(input int unsigned req);
		int unsigned need, cur, prev, split_at, spare, walked;
		logic [LINK_W-1:0] link;
		bit link_ok, cur_ok, have_prev;
		need      = (req + ALIGN_MASK) & ~ALIGN_MASK;
		cur       = list_head;
		cur_ok    = list_ok;
		prev      = 0;
		have_prev = 1'b0;
		for (walked = 0; walked < SLOT_COUNT && cur_ok; walked++) begin
			cur = cur % SLOT_COUNT;
			if (hdr_len[cur] >= need) begin
				link     = hdr_link[cur];
				link_ok  = hdr_link_ok[cur];
				split_at = cur * 8 + HEADER_BYTES + need;
				if (hdr_len[cur] > need + HEADER_BYTES && (split_at & ALIGN_MASK) == 0
						&& split_at / 8 < SLOT_COUNT) begin
					spare              = split_at / 8;
					hdr_len[spare]     = REQ_W'(hdr_len[cur] - need - HEADER_BYTES);
					hdr_link[spare]    = hdr_link[cur];
					hdr_link_ok[spare] = hdr_link_ok[cur];
					link               = LINK_W'(spare);
					link_ok            = 1'b1;
				end
				if (have_prev) begin
					hdr_link[prev]    = link;
					hdr_link_ok[prev] = link_ok;
				end else begin
					list_head = link;
					list_ok   = link_ok;
				end
				hdr_len[cur] = REQ_W'(need);
				return cur * 8 + HEADER_BYTES;
			end
			prev      = cur;
			have_prev = 1'b1;
			cur_ok    = hdr_link_ok[cur];
			cur       = hdr_link[cur];
		end
		return 0;
	endfunction

	// header slot of a payload offset, -1 when it cannot be a block
	function automatic int header_slot(input int unsigned a);
		if (a < HEADER_BYTES)
			return -1;
		if (((a - HEADER_BYTES) & ALIGN_MASK) != 0 || (a - HEADER_BYTES) / 8 >= SLOT_COUNT)
			return -1;
		return (a - HEADER_BYTES) / 8;
	endfunction

	function automatic void push_free(input int unsigned a);
		int s;
		s = header_slot(a);
		if (a == 0 || s < 0)
			return;
		hdr_link[s]    = list_head;
		hdr_link_ok[s] = list_ok;
		list_head      = LINK_W'(s);
		list_ok        = 1'b1;
	endfunction

	function automatic grant_t predict_grant(input logic [MODE_W-1:0] op,
			input int unsigned req, input int unsigned a);
		int unsigned res, copy, old, fresh;
		int s;
		res  = 0;
		copy = 0;
		case (op)
			MODE_ALLOC: res = carve_block(req);
			MODE_FREE:  push_free(a);
			MODE_REALLOC: begin
				if (a == 0)
					res = carve_block(req);
				else if (req == 0)
					push_free(a);
				else begin
					s = header_slot(a);
					if (s >= 0) begin
						old = hdr_len[s];
						if (old >= req)
							res = a;
						else begin
							fresh = carve_block(req);
							if (fresh != 0) begin
								copy = old;
								push_free(a);
								res  = fresh;
							end
						end
					end
				end
			end
			default: ;
		endcase
		return '{addr: ADDR_W'(res), grant: (res != 0), copy: REQ_W'(copy)};
	endfunction

	function automatic void check_field(input string field, input logic [REQ_W-1:0] want,
			input logic [REQ_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	// results are taken before the command of the same edge: the block shows
	// a result in the cycle it takes the next transfer
	always @(posedge clk or negedge arst_n) begin : compare
		grant_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				hdr_len[i]     = '0;
				hdr_link[i]    = '0;
				hdr_link_ok[i] = 1'b0;
			end
			hdr_len[0] = REQ_W'(POOL_BYTES - HEADER_BYTES);
			list_head  = '0;
			list_ok    = 1'b1;
			grants_due.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (grants_due.size() == 0) begin
					$error("result with no command outstanding: address %0d", result_address);
					errors++;
				end else begin
					want = grants_due.pop_front();
					check_field("result_address", REQ_W'(want.addr), REQ_W'(result_address));
					check_field("granted", REQ_W'(want.grant), REQ_W'(granted));
					check_field("copy_length", want.copy, copy_length);
				end
			end
			if (start && !busy)
				grants_due.push_back(predict_grant(mode, request_size, block_address));
			outstanding <= grants_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: first-fit free-list allocator
// Directed commands over the special cases, then random allocate, free and
// reallocate traffic in bursts; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffa_pkg::*;

	localparam int POOL_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int PERIOD       = 8;
	localparam int RANDOM_ITEMS = 600;
	// the last stretch may free foreign or stale blocks and so corrupt the list
	localparam int WILD_ITEMS   = 60;
	// worst walk is a full lap of the list per command
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int LIVE_CAP     = 48;
	localparam int FREED_CAP    = 16;

	// code with no meaning: block must answer with a null result
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [MODE_W-1:0] op;
		logic [REQ_W-1:0]  size;
		logic [ADDR_W-1:0] addr;
		bit                owned;
	} request_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              start         = 1'b0;
	logic [MODE_W-1:0] mode          = '0;
	logic [REQ_W-1:0]  request_size  = '0;
	logic [ADDR_W-1:0] block_address = '0;
	logic              busy;
	logic              done;
	logic [ADDR_W-1:0] result_address;
	logic              granted;
	logic [REQ_W-1:0]  copy_length;
	int                mismatches;
	int                outstanding;
	int                cycles = 0;

	// stimulus bookkeeping: blocks we believe we hold, and ones recently given back
	request_t          in_flight[$];
	logic [ADDR_W-1:0] live_blocks[$];
	logic [ADDR_W-1:0] freed_blocks[$];

	always #(PERIOD / 2) clk = ~clk;

	first_fit_free_list_allocator_unit #(
		.POOL_BYTES   (POOL_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.request_size   (request_size),
		.block_address  (block_address),
		.done           (done),
		.result_address (result_address),
		.granted        (granted),
		.copy_length    (copy_length)
	);

	allocator_checker #(
		.POOL_BYTES   (POOL_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.request_size   (request_size),
		.block_address  (block_address),
		.done           (done),
		.result_address (result_address),
		.granted        (granted),
		.copy_length    (copy_length),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	// hard stop; covers the clearing sweep after reset too
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void forget(input logic [ADDR_W-1:0] a);
		for (int i = 0; i < live_blocks.size(); i++)
			if (live_blocks[i] == a) begin
				live_blocks.delete(i);
				return;
			end
	endfunction

	function automatic void note_freed(input logic [ADDR_W-1:0] a);
		freed_blocks.push_back(a);
		if (freed_blocks.size() > FREED_CAP)
			void'(freed_blocks.pop_front());
	endfunction

	// mostly small sizes, now and then anything up to the whole pool
	function automatic logic [REQ_W-1:0] pick_size();
		if ($urandom_range(0, 15) != 0)
			return REQ_W'($urandom_range(0, 128));
		return ($urandom_range(0, 3) == 0) ? REQ_W'(4096) : REQ_W'($urandom_range(0, 4096));
	endfunction

	// Follow results so that later frees and reallocates name real blocks.
	// A block is dropped from the live list when its command goes out and
	// comes back only if the result says we still hold it.
	always @(posedge clk) begin : track_results
		request_t cmd;
		if (arst_n && done && in_flight.size() != 0) begin
			cmd = in_flight.pop_front();
			if (cmd.op == MODE_ALLOC || (cmd.op == MODE_REALLOC && cmd.addr == '0)) begin
				if (result_address != '0)
					live_blocks.push_back(result_address);
			end else if (cmd.op == MODE_REALLOC && cmd.size != '0) begin
				if (result_address != '0) begin
					live_blocks.push_back(result_address);
					if (cmd.owned && result_address != cmd.addr)
						note_freed(cmd.addr);
				end else if (cmd.owned)
					live_blocks.push_back(cmd.addr);   // failed move: old block kept
			end else if (cmd.owned)
				note_freed(cmd.addr);                   // free, or reallocate to size zero
		end
	end

	// one command transfer; start is left high for a back-to-back follower
	task automatic send(input logic [MODE_W-1:0] op, input logic [REQ_W-1:0] size,
			input logic [ADDR_W-1:0] addr, input bit owned);
		if (owned)
			forget(addr);
		start         <= 1'b1;
		mode          <= op;
		request_size  <= size;
		block_address <= addr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		in_flight.push_back('{op, size, addr, owned});
	endtask

	task automatic pause(input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every result due has come back
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic random_item(input bit wild);
		int r;
		logic [ADDR_W-1:0] a;
		r = $urandom_range(0, 99);
		if (wild && r < 50) begin
			// double frees and arbitrary offsets
			if (r < 12 && freed_blocks.size() != 0)
				send(MODE_FREE, REQ_W'($urandom_range(0, 4096)),
					freed_blocks[$urandom_range(0, freed_blocks.size() - 1)], 1'b0);
			else
				send(MODE_W'($urandom_range(0, 3)), REQ_W'($urandom_range(0, 4096)),
					ADDR_W'($urandom), 1'b0);
		end else if (live_blocks.size() == 0 || (r < 35 && live_blocks.size() < LIVE_CAP)) begin
			if ($urandom_range(0, 5) == 0)
				send(MODE_REALLOC, pick_size(), '0, 1'b0);
			else
				send(MODE_ALLOC, pick_size(), ADDR_W'($urandom), 1'b0);
		end else if (r < 62) begin
			a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
			if ($urandom_range(0, 4) == 0)
				send(MODE_REALLOC, '0, a, 1'b1);
			else
				send(MODE_FREE, REQ_W'($urandom_range(0, 4096)), a, 1'b1);
		end else if (r < 88) begin
			a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
			send(MODE_REALLOC, pick_size(), a, 1'b1);
		end else begin
			// noise the block must shrug off without touching the list
			case (r % 4)
				0: send(MODE_UNUSED, REQ_W'($urandom_range(0, 4096)), ADDR_W'($urandom), 1'b0);
				1: send(MODE_FREE, REQ_W'($urandom_range(0, 4096)), '0, 1'b0);
				2: begin
					a      = ADDR_W'($urandom);
					a[2:0] = 3'($urandom_range(1, 7));   // header not on an 8-byte slot
					send(r[0] ? MODE_FREE : MODE_REALLOC, pick_size(), a, 1'b0);
				end
				default: send(MODE_REALLOC, REQ_W'($urandom_range(1, 4096)),
					ADDR_W'($urandom_range(1, HEADER_BYTES - 1)), 1'b0);
			endcase
		end
	endtask

	initial begin : stimulus
		int sent, burst;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed; offsets follow from an empty pool
		send(MODE_ALLOC,   '0,           '0,       1'b0);   // size zero: 16
		send(MODE_ALLOC,   13'd1,        12'hFFF,  1'b0);   // rounds up to 8: 32
		send(MODE_ALLOC,   13'd4096,     '0,       1'b0);   // larger than pool: fails
		send(MODE_UNUSED,  13'd4096,     12'hFFF,  1'b0);   // meaningless code
		send(MODE_FREE,    13'd4096,     '0,       1'b0);   // null free ignored
		send(MODE_FREE,    '0,           12'd8,    1'b0);   // below a header: ignored
		send(MODE_FREE,    '0,           12'd33,   1'b0);   // off the slot grid: ignored
		send(MODE_FREE,    '0,           12'hFFF,  1'b0);
		send(MODE_REALLOC, 13'd24,       '0,       1'b0);   // null address: allocates 56
		send(MODE_REALLOC, 13'd8,        12'd12,   1'b0);   // invalid address: null
		send(MODE_REALLOC, 13'd8,        12'd32,   1'b1);   // fits in place
		send(MODE_REALLOC, 13'd100,      12'd32,   1'b1);   // grows: moves, copy 8
		send(MODE_ALLOC,   13'd8,        '0,       1'b0);   // exact hole, taken whole
		send(MODE_REALLOC, '0,           12'd16,   1'b1);   // size zero frees
		send(MODE_FREE,    '0,           12'd56,   1'b1);
		send(MODE_REALLOC, 13'd4096,     12'd96,   1'b1);   // cannot move: block kept
		send(MODE_ALLOC,   13'd3800,     '0,       1'b0);   // splits the big remainder
		send(MODE_ALLOC,   13'd64,       '0,       1'b0);   // tail taken exactly
		send(MODE_ALLOC,   13'd8,        '0,       1'b0);   // spare not above a header
		send(MODE_ALLOC,   13'd16,       '0,       1'b0);   // walks to the end, fails
		send(MODE_FREE,    '0,           12'd216,  1'b1);
		send(MODE_FREE,    '0,           12'd4032, 1'b1);
		settle();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				random_item(sent >= RANDOM_ITEMS - WILD_ITEMS);
				sent++;
			end
			if ($urandom_range(0, 15) == 0)
				settle();
			else
				pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
